// ----- hdl/voxel_ray_traversal_assert.svh -----
// Assertion macros shared by the voxel ray traversal block.
// Both macros expect signals named clk and rst in the calling module.
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH

// Same-cycle implication.
`define VRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/vrt_pkg.sv -----
package vrt_pkg;

  localparam int GRID_SIDE_DEF = 32;
  localparam int MAX_STEPS_DEF = 64;

  localparam int DIM_W    = 6;
  localparam int COORD_W  = 5;
  localparam int VAL_W    = 8;
  localparam int ORG_W    = 16;
  localparam int DIR_W    = 16;
  localparam int FRAC_W   = 11;
  localparam int MAG_W    = 16;
  localparam int CELL_W   = 8;
  localparam int TIME_W   = 30;
  localparam int STATUS_W = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Quotient bits of 2^30 / magnitude, one per divider cycle.
  localparam int DIV_STEPS = TIME_W + 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [REG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_RAY   = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EMPTY = 2'd0,
    ST_HIT   = 2'd1,
    ST_EXIT  = 2'd2,
    ST_LIMIT = 2'd3
  } status_t;

  // Per-axis ray setup, prepared when the item is taken in.
  typedef struct packed {
    logic [COORD_W-1:0] start;
    logic [FRAC_W-1:0]  frac;
    logic               neg;
    logic               zero;
    logic [MAG_W-1:0]   mag;
  } axis_t;

  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] wx;
    logic [COORD_W-1:0] wy;
    logic [COORD_W-1:0] wz;
    logic [VAL_W-1:0]   wv;
    axis_t [2:0]        axes;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_ADR1,
    B_ADR2,
    B_WRITE,
    B_DIV,
    B_MUL,
    B_STEP,
    B_READ,
    B_CHECK
  } back_state_t;

endpackage

// ----- hdl/voxel_ray_traversal.sv -----
// Voxel ray traversal: a byte-per-voxel grid plus a 3D DDA walker. An item
// is taken when start is high and busy is low; mode selects a voxel write
// or a ray cast. Results appear on the voxel and status ports for exactly
// one cycle under result_valid and cannot be stalled, so the receiver must
// take every result as it comes. After reset the block clears all
// GRID_SIDE^3 entries (32768 by default) of the voxel memory, one
// entry a cycle, with busy held high; configuration writes are still taken.
// Up to two items wait in an input queue while the back end works.
// A voxel write passes through two address multiply stages and then
// writes the memory. A ray first sets up each moving axis (the shared
// restoring divider yields one quotient bit a cycle for the reciprocal
// delta, then a multiply gives the first crossing); a still axis is set
// directly. Each step runs through step, two address multiply stages,
// memory read and check and reports one voxel; a step that leaves the
// grid reports the exit instead.
module voxel_ray_traversal #(
  parameter int GRID_SIDE = vrt_pkg::GRID_SIDE_DEF,
  parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode,
  input  logic [vrt_pkg::COORD_W-1:0]      write_x,
  input  logic [vrt_pkg::COORD_W-1:0]      write_y,
  input  logic [vrt_pkg::COORD_W-1:0]      write_z,
  input  logic [vrt_pkg::VAL_W-1:0]        write_value,
  input  logic [vrt_pkg::ORG_W-1:0]        origin_x,
  input  logic [vrt_pkg::ORG_W-1:0]        origin_y,
  input  logic [vrt_pkg::ORG_W-1:0]        origin_z,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_x,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_y,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_z,
  input  logic                             cfg_write,
  input  logic [vrt_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [vrt_pkg::DIM_W-1:0]        cfg_data,
  output logic                             result_valid,
  output logic [vrt_pkg::COORD_W-1:0]      voxel_x,
  output logic [vrt_pkg::COORD_W-1:0]      voxel_y,
  output logic [vrt_pkg::COORD_W-1:0]      voxel_z,
  output logic [vrt_pkg::VAL_W-1:0]        voxel_value,
  output logic [vrt_pkg::STATUS_W-1:0]     status,
  output logic                             last
);

`include "voxel_ray_traversal_assert.svh"

  localparam int EXT_W = $clog2(GRID_SIDE + 1);
  localparam int WIDE  = vrt_pkg::DIM_W + 2;

  logic [vrt_pkg::DIM_W-1:0] dim_x;
  logic [vrt_pkg::DIM_W-1:0] dim_y;
  logic [vrt_pkg::DIM_W-1:0] dim_z;
  logic [EXT_W-1:0]          ext_x;
  logic [EXT_W-1:0]          ext_y;
  logic [EXT_W-1:0]          ext_z;
  logic                      accept;
  logic                      q_full;
  logic                      pop;
  vrt_pkg::queue_head_t      head;
  vrt_pkg::back_status_t     back_info;

  // Extent registers. Index three and above are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= vrt_pkg::DIM_W'(32);
      dim_y <= vrt_pkg::DIM_W'(32);
      dim_z <= vrt_pkg::DIM_W'(32);
    end else if (cfg_write) begin
      case (cfg_index)
        vrt_pkg::REG_DIM_X: dim_x <= cfg_data;
        vrt_pkg::REG_DIM_Y: dim_y <= cfg_data;
        vrt_pkg::REG_DIM_Z: dim_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // An extent beyond the grid side is clamped to it.
  assign ext_x = (WIDE'(dim_x) > WIDE'(GRID_SIDE)) ? EXT_W'(GRID_SIDE) : EXT_W'(dim_x);
  assign ext_y = (WIDE'(dim_y) > WIDE'(GRID_SIDE)) ? EXT_W'(GRID_SIDE) : EXT_W'(dim_y);
  assign ext_z = (WIDE'(dim_z) > WIDE'(GRID_SIDE)) ? EXT_W'(GRID_SIDE) : EXT_W'(dim_z);

  assign busy   = back_info.clearing || q_full;
  assign accept = start && !busy;

  vrt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .mode        (mode),
    .write_x     (write_x),
    .write_y     (write_y),
    .write_z     (write_z),
    .write_value (write_value),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .origin_z    (origin_z),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .pop         (pop),
    .full        (q_full),
    .head        (head)
  );

  vrt_back #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_STEPS (MAX_STEPS),
    .EXT_W     (EXT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ext_x        (ext_x),
    .ext_y        (ext_y),
    .ext_z        (ext_z),
    .head         (head),
    .pop          (pop),
    .status_info  (back_info),
    .result_valid (result_valid),
    .voxel_x      (voxel_x),
    .voxel_y      (voxel_y),
    .voxel_z      (voxel_z),
    .voxel_value  (voxel_value),
    .status       (status),
    .last         (last)
  );

  // Only the final item of a ray may carry a status other than empty.
  `VRT_ASSERT_IMP(a_partial_empty, result_valid && !last, status == vrt_pkg::ST_EMPTY, "non-final result with terminal status")
  // The exit item carries zero coordinates and value.
  `VRT_ASSERT_IMP(a_exit_zero, result_valid && status == vrt_pkg::ST_EXIT, last && voxel_x == '0 && voxel_y == '0 && voxel_z == '0 && voxel_value == '0, "exit result not cleared")
  // A final result is never followed by another in the next cycle.
  `VRT_ASSERT_NXT(a_last_gap, result_valid && last, !result_valid, "result right after final result")
  // No results or queue pops while the memory is being cleared.
  `VRT_ASSERT_IMP(a_clear_quiet, back_info.clearing, !result_valid && !pop, "activity during clear")

endmodule

// ----- hdl/vrt_ram.sv -----
module vrt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/vrt_front.sv -----
// Takes items in, works out per-axis sign, magnitude and start cell, and
// holds them in a short queue for the back end.
module vrt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            mode,
  input  logic [vrt_pkg::COORD_W-1:0]     write_x,
  input  logic [vrt_pkg::COORD_W-1:0]     write_y,
  input  logic [vrt_pkg::COORD_W-1:0]     write_z,
  input  logic [vrt_pkg::VAL_W-1:0]       write_value,
  input  logic [vrt_pkg::ORG_W-1:0]       origin_x,
  input  logic [vrt_pkg::ORG_W-1:0]       origin_y,
  input  logic [vrt_pkg::ORG_W-1:0]       origin_z,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_x,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_y,
  input  logic signed [vrt_pkg::DIR_W-1:0] dir_z,
  input  logic                            pop,
  output logic                            full,
  output vrt_pkg::queue_head_t            head
);

  localparam int PTR_W = (vrt_pkg::QUEUE_DEPTH > 1) ? $clog2(vrt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(vrt_pkg::QUEUE_DEPTH + 1);

  function automatic vrt_pkg::axis_t classify(input logic [vrt_pkg::ORG_W-1:0] o,
                                               input logic [vrt_pkg::DIR_W-1:0] d);
    vrt_pkg::axis_t a;
    a.start = o[vrt_pkg::ORG_W-1:vrt_pkg::FRAC_W];
    a.frac  = o[vrt_pkg::FRAC_W-1:0];
    a.zero  = (d == '0);
    a.neg   = d[vrt_pkg::DIR_W-1];
    a.mag   = a.neg ? vrt_pkg::MAG_W'(~d + 1'b1) : vrt_pkg::MAG_W'(d);
    return a;
  endfunction

  vrt_pkg::item_t   slots [vrt_pkg::QUEUE_DEPTH];
  vrt_pkg::item_t   item_in;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  always_comb begin
    item_in.mode    = vrt_pkg::mode_t'(mode);
    item_in.wx      = write_x;
    item_in.wy      = write_y;
    item_in.wz      = write_z;
    item_in.wv      = write_value;
    item_in.axes[0] = classify(origin_x, dir_x);
    item_in.axes[1] = classify(origin_y, dir_y);
    item_in.axes[2] = classify(origin_z, dir_z);
  end

  assign full       = (count == CNT_W'(vrt_pkg::QUEUE_DEPTH));
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(vrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(vrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/vrt_div.sv -----
// Restoring divider for the reciprocal delta: 2^30 / divisor, one quotient
// bit per cycle, saturated to the largest crossing time.
module vrt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [vrt_pkg::MAG_W-1:0]    divisor,
  output logic                         done,
  output logic [vrt_pkg::TIME_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(vrt_pkg::DIV_STEPS);

  logic                          run;
  logic [STEP_W-1:0]             bit_idx;
  logic [vrt_pkg::MAG_W-1:0]     rem;
  logic [vrt_pkg::DIV_STEPS-1:0] q;
  logic [vrt_pkg::MAG_W:0]       shifted;
  logic                          fits;

  // The dividend is a single one in its top bit.
  assign shifted = {rem, (bit_idx == STEP_W'(vrt_pkg::DIV_STEPS - 1))};
  assign fits    = (shifted >= {1'b0, divisor});

  assign quotient = q[vrt_pkg::DIV_STEPS-1] ? vrt_pkg::TIME_MAX
                                            : q[vrt_pkg::TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && bit_idx == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      q       <= '0;
      bit_idx <= STEP_W'(vrt_pkg::DIV_STEPS - 1);
    end else if (run) begin
      rem     <= fits ? vrt_pkg::MAG_W'(shifted - {1'b0, divisor})
                      : shifted[vrt_pkg::MAG_W-1:0];
      q       <= {q[vrt_pkg::DIV_STEPS-2:0], fits};
      bit_idx <= bit_idx - 1'b1;
    end
  end

endmodule

// ----- hdl/vrt_back.sv -----
// Clears the voxel memory after reset, then carries out queued items: voxel
// writes, ray setup through the shared divider, and the DDA walk with one voxel memory read per step.
module vrt_back #(
  parameter int GRID_SIDE = vrt_pkg::GRID_SIDE_DEF,
  parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF,
  parameter int EXT_W     = $clog2(GRID_SIDE + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [EXT_W-1:0]              ext_x,
  input  logic [EXT_W-1:0]              ext_y,
  input  logic [EXT_W-1:0]              ext_z,
  input  vrt_pkg::queue_head_t          head,
  output logic                          pop,
  output vrt_pkg::back_status_t         status_info,
  output logic                          result_valid,
  output logic [vrt_pkg::COORD_W-1:0]   voxel_x,
  output logic [vrt_pkg::COORD_W-1:0]   voxel_y,
  output logic [vrt_pkg::COORD_W-1:0]   voxel_z,
  output logic [vrt_pkg::VAL_W-1:0]     voxel_value,
  output logic [vrt_pkg::STATUS_W-1:0]  status,
  output logic                          last
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int T1_W  = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int CMP_W = vrt_pkg::CELL_W - 1;
  localparam int MUL_W = vrt_pkg::FRAC_W + 1;

  vrt_pkg::back_state_t state, state_next;
  vrt_pkg::item_t       item;
  logic [1:0]           ai;
  logic                 div_wait;
  logic signed [vrt_pkg::CELL_W-1:0] pos [3];
  logic [vrt_pkg::TIME_W-1:0] tcross [3];
  logic [vrt_pkg::TIME_W-1:0] tdelta [3];
  logic [CNT_W-1:0]     step_count;
  logic [T1_W-1:0]      t1;
  logic [AW-1:0]        addr;
  logic [AW-1:0]        clr_cnt;

  logic                 clr_last;
  logic                 write_ok;
  vrt_pkg::axis_t       cur_axis;
  logic                 div_start;
  logic                 div_done;
  logic [vrt_pkg::TIME_W-1:0] div_q;
  logic [MUL_W-1:0]     mult;
  logic [vrt_pkg::TIME_W+MUL_W-1:0] prod;
  logic                 adv [3];
  logic [vrt_pkg::TIME_W:0] tsum [3];
  logic [vrt_pkg::TIME_W-1:0] tcross_n [3];
  logic signed [vrt_pkg::CELL_W-1:0] cell_n [3];
  logic [EXT_W-1:0]     ext [3];
  logic                 inside_n;
  logic                 at_limit;
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [vrt_pkg::VAL_W-1:0] ram_wdata;
  logic [vrt_pkg::VAL_W-1:0] ram_rdata;
  logic                 emit_exit;
  logic                 emit_check;

  assign ext[0] = ext_x;
  assign ext[1] = ext_y;
  assign ext[2] = ext_z;

  assign clr_last = (clr_cnt == AW'(DEPTH - 1));
  assign write_ok = (CMP_W'(head.item.wx) < CMP_W'(ext_x)) &&
                    (CMP_W'(head.item.wy) < CMP_W'(ext_y)) &&
                    (CMP_W'(head.item.wz) < CMP_W'(ext_z));
  assign cur_axis = item.axes[ai];
  assign at_limit = (step_count >= CNT_W'(MAX_STEPS));

  // First crossing: the distance to the next boundary as a share of delta.
  assign mult = cur_axis.neg ? {1'b0, cur_axis.frac}
                             : MUL_W'(MUL_W'(1) << vrt_pkg::FRAC_W) - MUL_W'(cur_axis.frac);
  assign prod = tdelta[ai] * mult;

  // One DDA step: every axis tied for the earliest crossing moves.
  always_comb begin
    adv[0] = (tcross[0] <= tcross[1]) && (tcross[0] <= tcross[2]);
    adv[1] = (tcross[1] <= tcross[2]) && (tcross[1] <= tcross[0]);
    adv[2] = (tcross[2] <= tcross[0]) && (tcross[2] <= tcross[1]);
    inside_n = 1'b1;
    for (int k = 0; k < 3; k++) begin
      tsum[k]     = {1'b0, tcross[k]} + {1'b0, tdelta[k]};
      tcross_n[k] = tcross[k];
      cell_n[k]   = pos[k];
      if (adv[k]) begin
        tcross_n[k] = tsum[k][vrt_pkg::TIME_W] ? vrt_pkg::TIME_MAX
                                               : tsum[k][vrt_pkg::TIME_W-1:0];
        if (!item.axes[k].zero) begin
          cell_n[k] = item.axes[k].neg ? pos[k] - 1'b1 : pos[k] + 1'b1;
        end
      end
      if (cell_n[k][vrt_pkg::CELL_W-1] ||
          cell_n[k][CMP_W-1:0] >= CMP_W'(ext[k])) begin
        inside_n = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vrt_pkg::B_CLEAR: begin
        if (clr_last) begin
          state_next = vrt_pkg::B_IDLE;
        end
      end
      vrt_pkg::B_IDLE: begin
        if (head.valid) begin
          if (head.item.mode == vrt_pkg::MODE_WRITE) begin
            state_next = write_ok ? vrt_pkg::B_ADR1 : vrt_pkg::B_IDLE;
          end else begin
            state_next = vrt_pkg::B_DIV;
          end
        end
      end
      vrt_pkg::B_ADR1: state_next = vrt_pkg::B_ADR2;
      vrt_pkg::B_ADR2: begin
        state_next = (item.mode == vrt_pkg::MODE_WRITE) ? vrt_pkg::B_WRITE
                                                        : vrt_pkg::B_READ;
      end
      vrt_pkg::B_WRITE: state_next = vrt_pkg::B_IDLE;
      vrt_pkg::B_DIV: begin
        if (cur_axis.zero) begin
          state_next = (ai == 2'd2) ? vrt_pkg::B_STEP : vrt_pkg::B_DIV;
        end else if (div_done) begin
          state_next = vrt_pkg::B_MUL;
        end
      end
      vrt_pkg::B_MUL: state_next = (ai == 2'd2) ? vrt_pkg::B_STEP : vrt_pkg::B_DIV;
      vrt_pkg::B_STEP: state_next = inside_n ? vrt_pkg::B_ADR1 : vrt_pkg::B_IDLE;
      vrt_pkg::B_READ: state_next = vrt_pkg::B_CHECK;
      vrt_pkg::B_CHECK: begin
        state_next = (ram_rdata != '0 || at_limit) ? vrt_pkg::B_IDLE : vrt_pkg::B_STEP;
      end
      default: state_next = vrt_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == vrt_pkg::B_IDLE) && head.valid;
    div_start  = (state == vrt_pkg::B_DIV) && !cur_axis.zero && !div_wait;
    ram_we     = (state == vrt_pkg::B_CLEAR) || (state == vrt_pkg::B_WRITE);
    ram_re     = (state == vrt_pkg::B_READ);
    ram_waddr  = (state == vrt_pkg::B_CLEAR) ? clr_cnt : addr;
    ram_wdata  = (state == vrt_pkg::B_CLEAR) ? '0 : item.wv;
    emit_exit  = (state == vrt_pkg::B_STEP) && !inside_n;
    emit_check = (state == vrt_pkg::B_CHECK);
    status_info.clearing = (state == vrt_pkg::B_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vrt_pkg::B_CLEAR;
      clr_cnt      <= '0;
      div_wait     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit_exit || emit_check;
      if (state == vrt_pkg::B_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (div_start) begin
        div_wait <= 1'b1;
      end else if (div_done) begin
        div_wait <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      vrt_pkg::B_IDLE: begin
        item       <= head.item;
        ai         <= '0;
        step_count <= '0;
        if (head.item.mode == vrt_pkg::MODE_WRITE) begin
          pos[0] <= vrt_pkg::CELL_W'(head.item.wx);
          pos[1] <= vrt_pkg::CELL_W'(head.item.wy);
          pos[2] <= vrt_pkg::CELL_W'(head.item.wz);
        end else begin
          for (int k = 0; k < 3; k++) begin
            pos[k] <= vrt_pkg::CELL_W'(head.item.axes[k].start);
          end
        end
      end
      vrt_pkg::B_ADR1: begin
        t1 <= T1_W'(T1_W'(ext_y) * T1_W'(pos[2][CW-1:0]) + T1_W'(pos[1][CW-1:0]));
      end
      vrt_pkg::B_ADR2: begin
        addr <= AW'(AW'(ext_x) * AW'(t1) + AW'(pos[0][CW-1:0]));
      end
      vrt_pkg::B_DIV: begin
        if (cur_axis.zero) begin
          tdelta[ai] <= vrt_pkg::TIME_MAX;
          tcross[ai] <= vrt_pkg::TIME_MAX;
          ai         <= ai + 1'b1;
        end else if (div_done) begin
          tdelta[ai] <= div_q;
        end
      end
      vrt_pkg::B_MUL: begin
        tcross[ai] <= prod[vrt_pkg::TIME_W+vrt_pkg::FRAC_W-1:vrt_pkg::FRAC_W];
        ai         <= ai + 1'b1;
      end
      vrt_pkg::B_STEP: begin
        for (int k = 0; k < 3; k++) begin
          tcross[k] <= tcross_n[k];
          pos[k]    <= cell_n[k];
        end
        step_count <= step_count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result registers: the exit item carries zero coordinates and value.
  always_ff @(posedge clk) begin
    if (emit_exit) begin
      voxel_x     <= '0;
      voxel_y     <= '0;
      voxel_z     <= '0;
      voxel_value <= '0;
      status      <= vrt_pkg::ST_EXIT;
      last        <= 1'b1;
    end else if (emit_check) begin
      voxel_x     <= pos[0][vrt_pkg::COORD_W-1:0];
      voxel_y     <= pos[1][vrt_pkg::COORD_W-1:0];
      voxel_z     <= pos[2][vrt_pkg::COORD_W-1:0];
      voxel_value <= ram_rdata;
      if (ram_rdata != '0) begin
        status <= vrt_pkg::ST_HIT;
        last   <= 1'b1;
      end else if (at_limit) begin
        status <= vrt_pkg::ST_LIMIT;
        last   <= 1'b1;
      end else begin
        status <= vrt_pkg::ST_EMPTY;
        last   <= 1'b0;
      end
    end
  end

  vrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (cur_axis.mag),
    .done     (div_done),
    .quotient (div_q)
  );

  vrt_ram #(
    .WIDTH (vrt_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

endmodule

// ----- dv/tb_voxel_ray_traversal.sv -----
module tb_voxel_ray_traversal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = 32;
  localparam int STEP_LIMIT = 64;
  localparam logic [29:0] T_SAT = '1;

  // One input item as the driver sees it.
  typedef struct packed {
    vrt_pkg::mode_t    kind;
    logic [4:0]        wx;
    logic [4:0]        wy;
    logic [4:0]        wz;
    logic [7:0]        wv;
    logic [2:0][15:0]  org;
    logic [2:0][15:0]  dir;
  } ray_item_t;

  // One visited voxel (or the exit marker) on the result ports.
  typedef struct packed {
    logic [4:0]       x;
    logic [4:0]       y;
    logic [4:0]       z;
    logic [7:0]       value;
    vrt_pkg::status_t st;
    logic             fin;
  } visit_t;

  // Scoreboard: keeps its own copy of the grid and the extents, walks each
  // accepted ray and queues the voxels the block is expected to report.
  class ray_scoreboard;
    byte unsigned grid[GRID*GRID*GRID];
    logic [5:0]   dim[3];
    visit_t       visits_due[$];
    int           errors;

    function new();
      foreach (grid[i]) grid[i] = 0;
      foreach (dim[a]) dim[a] = 6'd32;
      errors = 0;
    endfunction

    function void set_dim(int a, logic [5:0] v);
      dim[a] = v;
    endfunction

    function int ext(int a);
      return (dim[a] > GRID) ? GRID : int'(dim[a]);
    endfunction

    function int flat(int x, int y, int z);
      return x + ext(0) * (y + ext(1) * z);
    endfunction

    function void push_visit(int x, int y, int z, int v, vrt_pkg::status_t s, bit f);
      visit_t e;
      e.x = x[4:0];
      e.y = y[4:0];
      e.z = z[4:0];
      e.value = v[7:0];
      e.st = s;
      e.fin = f;
      visits_due = {visits_due, e};
    endfunction

    // Called once per accepted item.
    function void note_item(ray_item_t it);
      int          pos[3];
      int          stp[3];
      logic [29:0] dlt[3];
      logic [29:0] tm[3];
      bit          adv[3];
      bit          in_grid;
      longint      q;
      longint      mag;
      longint      frac;
      longint      sum;
      int          v;
      if (it.kind == vrt_pkg::MODE_WRITE) begin
        if (it.wx < ext(0) && it.wy < ext(1) && it.wz < ext(2))
          grid[flat(it.wx, it.wy, it.wz)] = it.wv;
        return;
      end
      for (int a = 0; a < 3; a++) begin
        pos[a] = it.org[a][15:11];
        frac = it.org[a][10:0];
        if (it.dir[a] == 16'd0) begin
          stp[a] = 0;
          dlt[a] = T_SAT;
          tm[a] = T_SAT;
        end else begin
          stp[a] = it.dir[a][15] ? -1 : 1;
          mag = it.dir[a][15] ? (65536 - longint'(it.dir[a])) : longint'(it.dir[a]);
          q = (64'd1 << 30) / mag;
          dlt[a] = (q > T_SAT) ? T_SAT : q[29:0];
          q = (stp[a] > 0) ? ((longint'(dlt[a]) * (2048 - frac)) >> 11)
                           : ((longint'(dlt[a]) * frac) >> 11);
          tm[a] = (q > T_SAT) ? T_SAT : q[29:0];
        end
      end
      for (int n = 1; n <= STEP_LIMIT; n++) begin
        // Every axis tied for the earliest crossing advances together.
        adv[0] = tm[0] <= tm[1] && tm[0] <= tm[2];
        adv[1] = tm[1] <= tm[2] && tm[1] <= tm[0];
        adv[2] = tm[2] <= tm[0] && tm[2] <= tm[1];
        in_grid = 1;
        for (int a = 0; a < 3; a++) begin
          if (adv[a]) begin
            sum = longint'(tm[a]) + longint'(dlt[a]);
            tm[a] = (sum > T_SAT) ? T_SAT : sum[29:0];
            pos[a] += stp[a];
          end
          if (pos[a] < 0 || pos[a] >= ext(a)) in_grid = 0;
        end
        if (!in_grid) begin
          push_visit(0, 0, 0, 0, vrt_pkg::ST_EXIT, 1);
          return;
        end
        v = grid[flat(pos[0], pos[1], pos[2])];
        if (v != 0) begin
          push_visit(pos[0], pos[1], pos[2], v, vrt_pkg::ST_HIT, 1);
          return;
        end
        if (n == STEP_LIMIT) begin
          push_visit(pos[0], pos[1], pos[2], 0, vrt_pkg::ST_LIMIT, 1);
          return;
        end
        push_visit(pos[0], pos[1], pos[2], 0, vrt_pkg::ST_EMPTY, 0);
      end
    endfunction

    // Called for every result strobe.
    function void check_result(visit_t got);
      visit_t want;
      if (visits_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = visits_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic mode = 0;
  logic [4:0] write_x = 0, write_y = 0, write_z = 0;
  logic [7:0] write_value = 0;
  logic [15:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [15:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic cfg_write = 0;
  logic [1:0] cfg_index = 0;
  logic [5:0] cfg_data = 0;
  logic result_valid;
  logic [4:0] voxel_x, voxel_y, voxel_z;
  logic [7:0] voxel_value;
  logic [1:0] status;
  logic last;

  ray_scoreboard sb = new();
  int idle_pct = 0;

  always #6 clk = ~clk;

  voxel_ray_traversal u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .write_x(write_x), .write_y(write_y), .write_z(write_z),
    .write_value(write_value),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid),
    .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
    .voxel_value(voxel_value), .status(status), .last(last)
  );

  // Results cannot be held off, so every strobe is checked as it comes.
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_result({voxel_x, voxel_y, voxel_z, voxel_value,
                       vrt_pkg::status_t'(status), last});
  end

  // Offers one item. Start stays high from one item to the next unless the
  // sender decides to idle, in which case it drops start low first.
  task automatic send(ray_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(7)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start = 1;
    mode = it.kind;
    write_x = it.wx;
    write_y = it.wy;
    write_z = it.wz;
    write_value = it.wv;
    origin_x = it.org[0];
    origin_y = it.org[1];
    origin_z = it.org[2];
    dir_x = it.dir[0];
    dir_y = it.dir[1];
    dir_z = it.dir[2];
    // The item is taken at the first rising edge that sees busy low.
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  function automatic ray_item_t make_write(int x, int y, int z, int v);
    ray_item_t it;
    it = '0;
    it.kind = vrt_pkg::MODE_WRITE;
    it.wx = 5'(x);
    it.wy = 5'(y);
    it.wz = 5'(z);
    it.wv = 8'(v);
    return it;
  endfunction

  function automatic ray_item_t make_ray(logic [15:0] ox, logic [15:0] oy,
                                         logic [15:0] oz, logic [15:0] dx,
                                         logic [15:0] dy, logic [15:0] dz);
    ray_item_t it;
    it = '0;
    it.kind = vrt_pkg::MODE_RAY;
    it.org = {oz, oy, ox};
    it.dir = {dz, dy, dx};
    return it;
  endfunction

  // Lets every outstanding ray finish, then a margin for trailing writes,
  // which produce no result but may still be in the queue.
  task automatic drain();
    @(negedge clk);
    start = 0;
    wait (sb.visits_due.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_extents(logic [5:0] dx, logic [5:0] dy, logic [5:0] dz);
    logic [5:0] vals[3];
    logic [1:0] idx[3];
    vals = '{dx, dy, dz};
    idx = '{vrt_pkg::REG_DIM_X, vrt_pkg::REG_DIM_Y, vrt_pkg::REG_DIM_Z};
    for (int a = 0; a < 3; a++) begin
      @(negedge clk);
      cfg_write = 1;
      cfg_index = idx[a];
      cfg_data = vals[a];
      sb.set_dim(a, vals[a]);
    end
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'd16384;
      3: return -16'sd16384;
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // Random traffic: voxel writes mostly inside the extents and rays mostly
  // cast from inside the grid, plus some stray writes and full-range
  // origins and directions.
  task automatic random_phase(int count);
    ray_item_t it;
    int lim[3];
    for (int a = 0; a < 3; a++) lim[a] = (sb.ext(a) > 0) ? sb.ext(a) - 1 : 0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(9) == 0)
          it = make_write($urandom_range(31), $urandom_range(31), $urandom_range(31),
                          $urandom_range(255));
        else
          it = make_write($urandom_range(lim[0]), $urandom_range(lim[1]),
                          $urandom_range(lim[2]),
                          ($urandom_range(5) == 0) ? 0 : $urandom_range(255, 1));
      end else if ($urandom_range(9) == 0) begin
        it = make_ray(16'($urandom), 16'($urandom), 16'($urandom),
                      rand_dir(), rand_dir(), rand_dir());
      end else begin
        it = make_ray({5'($urandom_range(lim[0])), 11'($urandom)},
                      {5'($urandom_range(lim[1])), 11'($urandom)},
                      {5'($urandom_range(lim[2])), 11'($urandom)},
                      rand_dir(), rand_dir(), rand_dir());
      end
      send(it);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Registers may be written while the memory clears after reset.
    set_extents(6'd32, 6'd32, 6'd32);

    // Directed part on the full grid.
    send(make_write(5, 0, 0, 1));
    send(make_write(31, 31, 31, 8'h80));
    send(make_write(0, 31, 0, 8'hFF));
    send(make_write(3, 3, 3, 0));
    // No direction at all: the ray sits still until the step limit.
    send(make_ray(16'h0400, 16'h0400, 16'h0400, 16'd0, 16'd0, 16'd0));
    // Along +x into the solid voxel at x=5.
    send(make_ray(16'h0400, 16'h0400, 16'h0400, 16'd16384, 16'd0, 16'd0));
    // Along -x out of cell zero: leaves the grid on the first step.
    send(make_ray(16'h0400, 16'h0400, 16'h0400, -16'sd16384, 16'd0, 16'd0));
    // Exact diagonal: all three axes tie and step together to the far corner.
    send(make_ray(16'hA000, 16'hA000, 16'hA000, 16'd16384, 16'd16384, 16'd16384));
    send(make_ray(16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd16384, -16'sd16384,
                  -16'sd16384));
    // Direction extremes and a tiny component whose delta saturates.
    send(make_ray(16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1));
    send(make_ray(16'h07FF, 16'h0800, 16'h1234, 16'd1, 16'hFFFF, 16'd0));
    send(make_ray(16'h0000, 16'hFFFF, 16'h0000, 16'd0, -16'sd16384, 16'd0));
    send(make_ray(16'h0000, 16'h0000, 16'hFFFF, 16'd0, 16'd0, 16'd16384));
    send(make_ray(16'h5555, 16'hAAAA, 16'h3C3C, 16'd9000, -16'sd3000, 16'd200));

    // Hold off until every expected result has come back.
    drain();
    set_extents(6'd8, 6'd8, 6'd8);
    idle_pct = 0;
    random_phase(35);

    drain();
    set_extents(6'd32, 6'd32, 6'd32);
    idle_pct = 79;
    random_phase(35);

    drain();
    set_extents(6'd63, 6'd1, 6'd5);
    idle_pct = 36;
    random_phase(35);

    // Zero extent on x: writes are dropped and every ray leaves at once.
    drain();
    set_extents(6'd0, 6'd16, 6'd32);
    idle_pct = 0;
    random_phase(15);

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Far beyond the memory clear plus every ray running to the step limit.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
